// ===== design/frg_pkg.sv =====
// Shared types and constants for the fraction reduction block.
// No dependencies; imported by frg_gcd, frg_div and fraction_reduce_gcd_unit.
package frg_pkg;

  localparam int WORD_BITS = 32;
  // holds a shift count of up to WORD_BITS-1
  localparam int SHIFT_BITS = $clog2(WORD_BITS);
  // counts divider steps 0..WORD_BITS
  localparam int STEP_BITS = $clog2(WORD_BITS + 1);

  typedef struct packed {
    logic signed [WORD_BITS-1:0] numerator;
    logic signed [WORD_BITS-1:0] denominator;
    logic                        last_item;
  } frg_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] reduced_numerator;
    logic signed [WORD_BITS-1:0] reduced_denominator;
    logic                        last_result;
  } frg_out_t;

endpackage

// ===== design/frg_gcd.sv =====
// Binary (Stein) gcd of a positive value and an unsigned value, one step per cycle.
// Depends on frg_pkg.
module frg_gcd (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [frg_pkg::WORD_BITS-1:0] a_in,
  input  logic [frg_pkg::WORD_BITS-1:0] b_in,
  output logic                          done,
  output logic [frg_pkg::WORD_BITS-1:0] g_out
);
  import frg_pkg::*;

  logic                  run_r;
  logic                  done_r;
  logic [WORD_BITS-1:0]  a_r;
  logic [WORD_BITS-1:0]  b_r;
  logic [SHIFT_BITS-1:0] k_r;
  logic [WORD_BITS-1:0]  g_r;
  logic [WORD_BITS:0]    diff;
  logic                  a_lt_b;
  logic [WORD_BITS-1:0]  diff_mag;
  logic                  finish;

  // borrow of a - b picks which operand the difference replaces
  assign diff     = {1'b0, a_r} - {1'b0, b_r};
  assign a_lt_b   = diff[WORD_BITS];
  assign diff_mag = a_lt_b ? (b_r - a_r) : diff[WORD_BITS-1:0];
  assign finish   = (b_r == '0) || (diff == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        a_r   <= a_in;
        b_r   <= b_in;
        k_r   <= '0;
      end else if (run_r) begin
        if (finish) begin
          g_r    <= a_r << k_r;
          done_r <= 1'b1;
          run_r  <= 1'b0;
        end else if (!a_r[0] && !b_r[0]) begin
          a_r <= a_r >> 1;
          b_r <= b_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_r <= a_r >> 1;
        end else if (!b_r[0]) begin
          b_r <= b_r >> 1;
        end else if (a_lt_b) begin
          // difference of two odd values is even: halve it at once
          b_r <= diff_mag >> 1;
        end else begin
          a_r <= diff_mag >> 1;
        end
      end
    end
  end

  assign done  = done_r;
  assign g_out = g_r;

endmodule

// ===== design/frg_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on frg_pkg.
module frg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [frg_pkg::WORD_BITS-1:0] dividend,
  input  logic [frg_pkg::WORD_BITS-1:0] divisor,
  output logic                          done,
  output logic [frg_pkg::WORD_BITS-1:0] quotient
);
  import frg_pkg::*;

  logic                 run_r;
  logic                 done_r;
  logic [STEP_BITS-1:0] cnt_r;
  logic [WORD_BITS-1:0] dvs_r;
  // partial remainder stays below the divisor, so it fits in one word
  logic [WORD_BITS-1:0] rem_r;
  // dividend bits shift out of the top while quotient bits shift in below
  logic [WORD_BITS-1:0] q_r;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   sub;
  logic                 fits;

  assign trial = {rem_r, q_r[WORD_BITS-1]};
  assign sub   = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        dvs_r <= divisor;
        rem_r <= '0;
        q_r   <= dividend;
      end else if (run_r) begin
        rem_r <= fits ? sub[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
        q_r   <= {q_r[WORD_BITS-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_BITS'(WORD_BITS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== design/fraction_reduce_gcd_unit.sv =====
// Top level of the fraction reduction block: sequencer around gcd and divider.
// Depends on frg_pkg, frg_gcd and frg_div.
//
// Handles one signed fraction per transfer, reducing it to lowest terms when its
// numerator is positive. A transfer is taken when start is high and busy is low;
// the result appears on out_data for exactly one cycle with out_valid high and
// cannot be held off by the receiver, so it must be captured in that cycle. A
// zero or negative numerator passes through unchanged, with the result in the
// cycle after the transfer and busy never rising. A positive numerator runs a
// binary gcd (one shift or subtract-and-halve step a cycle), then two exact
// divisions by the gcd on one shared restoring divider; busy is high from the
// transfer until the result, since the gcd loop and the divider hold one item at
// a time. The denominator's sign is kept; its magnitude, 2^(WORD_BITS-1)
// included, is treated as unsigned. With a positive numerator, a zero
// denominator gives the result 1/0.
module fraction_reduce_gcd_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  frg_pkg::frg_in_t  in_data,
  output logic              out_valid,
  output frg_pkg::frg_out_t out_data
);
  import frg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN
  } state_t;

  state_t               state_r;
  logic                 out_valid_r;
  frg_out_t             out_data_r;
  logic [WORD_BITS-1:0] num_r;
  logic [WORD_BITS-1:0] den_mag_r;
  logic                 den_neg_r;
  logic                 last_r;
  logic [WORD_BITS-1:0] g_r;
  logic [WORD_BITS-1:0] q_num_r;

  logic                 accept;
  logic                 num_pos;
  logic                 in_den_neg;
  logic [WORD_BITS-1:0] in_den_mag;
  logic                 gcd_go;
  logic                 gcd_done;
  logic [WORD_BITS-1:0] gcd_g;
  logic                 div_go;
  logic [WORD_BITS-1:0] div_dividend;
  logic                 div_done;
  logic [WORD_BITS-1:0] div_q;
  logic [WORD_BITS-1:0] q_den;

  assign accept     = start && (state_r == ST_IDLE);
  assign num_pos    = !in_data.numerator[WORD_BITS-1] && (in_data.numerator != '0);
  assign in_den_neg = in_data.denominator[WORD_BITS-1];
  assign in_den_mag = in_den_neg ? (WORD_BITS'(0) - in_data.denominator)
                                 : in_data.denominator;

  // gcd starts straight from the port; the divider is reused for both parts
  assign gcd_go       = accept && num_pos;
  assign div_go       = gcd_done || ((state_r == ST_DIV_NUM) && div_done);
  assign div_dividend = gcd_done ? num_r : den_mag_r;
  assign q_den        = den_neg_r ? (WORD_BITS'(0) - div_q) : div_q;

  frg_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (gcd_go),
    .a_in  (in_data.numerator),
    .b_in  (in_den_mag),
    .done  (gcd_done),
    .g_out (gcd_g)
  );

  frg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (gcd_done ? gcd_g : g_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            num_r     <= in_data.numerator;
            den_mag_r <= in_den_mag;
            den_neg_r <= in_den_neg;
            last_r    <= in_data.last_item;
            if (num_pos) begin
              state_r <= ST_GCD;
            end else begin
              // zero or negative numerator: pass the fraction through unchanged
              out_valid_r                    <= 1'b1;
              out_data_r.reduced_numerator   <= in_data.numerator;
              out_data_r.reduced_denominator <= in_data.denominator;
              out_data_r.last_result         <= in_data.last_item;
            end
          end
        end
        ST_GCD: begin
          if (gcd_done) begin
            g_r     <= gcd_g;
            state_r <= ST_DIV_NUM;
          end
        end
        ST_DIV_NUM: begin
          if (div_done) begin
            q_num_r <= div_q;
            state_r <= ST_DIV_DEN;
          end
        end
        ST_DIV_DEN: begin
          if (div_done) begin
            out_valid_r                    <= 1'b1;
            out_data_r.reduced_numerator   <= q_num_r;
            out_data_r.reduced_denominator <= q_den;
            out_data_r.last_result         <= last_r;
            state_r                        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
